/* rtl/core/dcw_pkg.sv */
package dcw_pkg;

    // Field widths
    localparam int unsigned YearW  = 14;
    localparam int unsigned MonthW = 4;
    localparam int unsigned DayW   = 5;
    localparam int unsigned CentW  = 8;   // year / 100 for any 14-bit year
    localparam int unsigned RemW   = 7;   // year % 100
    localparam int unsigned LeapW  = 13;  // leap years in 1..year
    localparam int unsigned SumW   = 15;  // day total before reduction mod 7
    localparam int unsigned StatW  = 3;
    localparam int unsigned WdayW  = 3;

    // Valid calendar range
    localparam logic [YearW-1:0] FirstYear = YearW'(1000);
    localparam logic [YearW-1:0] LastYear  = YearW'(9999);

    // Reciprocal of 100: (y * 5243) >> 19 is exact for y below 43690
    localparam int unsigned     CentShift = 19;
    localparam int unsigned     ProdW     = YearW + 13;
    localparam logic [ProdW-1:0] CentMul  = ProdW'(5243);
    localparam logic [YearW-1:0] Hundred  = YearW'(100);

    // Offset that folds the epoch (Wednesday 1000-01-01) into the sum mod 7
    localparam logic [SumW-1:0] EpochOffset = SumW'(5);

    // Month numbers
    localparam logic [MonthW-1:0] MonFeb = MonthW'(2);
    localparam logic [MonthW-1:0] MonApr = MonthW'(4);
    localparam logic [MonthW-1:0] MonJun = MonthW'(6);
    localparam logic [MonthW-1:0] MonSep = MonthW'(9);
    localparam logic [MonthW-1:0] MonNov = MonthW'(11);
    localparam logic [MonthW-1:0] MonDec = MonthW'(12);

    typedef enum logic [StatW-1:0] {
        ST_OK          = 3'd0,
        ST_BAD_YEAR    = 3'd1,
        ST_BAD_MONTH   = 3'd2,
        ST_BAD_DAY     = 3'd3,
        ST_OVER_30     = 3'd4,
        ST_FEB_OVER_28 = 3'd5,
        ST_FEB_OVER_29 = 3'd6
    } status_t;

    // After the century split
    typedef struct packed {
        logic [YearW-1:0]  year;
        logic [MonthW-1:0] month;
        logic [DayW-1:0]   day;
        logic [CentW-1:0]  cent;
    } split_t;

    // After remainder and leap count
    typedef struct packed {
        logic [YearW-1:0]  year;
        logic [MonthW-1:0] month;
        logic [DayW-1:0]   day;
        logic [CentW-1:0]  cent;
        logic [RemW-1:0]   rem;
        logic [LeapW-1:0]  leaps;
    } count_t;

    // After the checks and day total
    typedef struct packed {
        status_t          status;
        logic [SumW-1:0]  total;
    } check_t;

    // Days before the first of each month in a common year
    function automatic logic [8:0] days_before(input logic [MonthW-1:0] month);
        logic [8:0] days;
        unique case (month)
            4'd1:    days = 9'd0;
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

/* rtl/core/dcw_year_stage.sv */
module dcw_year_stage (
    input  logic                          aclk,
    input  logic                          adv1,
    input  logic                          adv2,
    input  logic [dcw_pkg::YearW-1:0]     year_value,
    input  logic [dcw_pkg::MonthW-1:0]    month_value,
    input  logic [dcw_pkg::DayW-1:0]      day_value,
    output dcw_pkg::count_t               count_out
);

    dcw_pkg::split_t split_reg, split_next;
    dcw_pkg::count_t count_reg, count_next;
    logic [dcw_pkg::ProdW-1:0] prod;
    logic [dcw_pkg::YearW-1:0] cent_x100;
    logic [dcw_pkg::YearW-1:0] rem_full;

    // Split off the century by reciprocal multiplication
    always_comb begin
        prod             = dcw_pkg::ProdW'(year_value) * dcw_pkg::CentMul;
        split_next.year  = year_value;
        split_next.month = month_value;
        split_next.day   = day_value;
        split_next.cent  = prod[dcw_pkg::CentShift +: dcw_pkg::CentW];
    end

    // Remainder within the century and leap years up to this year
    always_comb begin
        cent_x100        = dcw_pkg::YearW'(split_reg.cent) * dcw_pkg::Hundred;
        rem_full         = split_reg.year - cent_x100;
        count_next.year  = split_reg.year;
        count_next.month = split_reg.month;
        count_next.day   = split_reg.day;
        count_next.cent  = split_reg.cent;
        count_next.rem   = rem_full[dcw_pkg::RemW-1:0];
        count_next.leaps = dcw_pkg::LeapW'(split_reg.year[dcw_pkg::YearW-1:2])
                         - dcw_pkg::LeapW'(split_reg.cent)
                         + dcw_pkg::LeapW'(split_reg.cent[dcw_pkg::CentW-1:2]);
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            split_reg <= split_next;
        end
        if (adv2) begin
            count_reg <= count_next;
        end
    end

    assign count_out = count_reg;

endmodule

/* rtl/core/dcw_check_stage.sv */
module dcw_check_stage (
    input  logic               aclk,
    input  logic               adv,
    input  dcw_pkg::count_t    count_in,
    output dcw_pkg::check_t    check_out
);

    dcw_pkg::check_t check_reg, check_next;
    logic leap;
    logic thirty_month;
    logic feb;
    logic late_adj;

    always_comb begin
        // Leap rule: by 4 and not by 100, or by 400
        leap = ((count_in.year[1:0] == 2'd0) && (count_in.rem != '0))
            || ((count_in.rem == '0) && (count_in.cent[1:0] == 2'd0));
        thirty_month = (count_in.month == dcw_pkg::MonApr)
                    || (count_in.month == dcw_pkg::MonJun)
                    || (count_in.month == dcw_pkg::MonSep)
                    || (count_in.month == dcw_pkg::MonNov);
        feb      = (count_in.month == dcw_pkg::MonFeb);
        late_adj = leap && (count_in.month > dcw_pkg::MonFeb);

        // First failing check sets the status
        priority if ((count_in.year < dcw_pkg::FirstYear)
                     || (count_in.year > dcw_pkg::LastYear)) begin
            check_next.status = dcw_pkg::ST_BAD_YEAR;
        end else if ((count_in.month == '0) || (count_in.month > dcw_pkg::MonDec)) begin
            check_next.status = dcw_pkg::ST_BAD_MONTH;
        end else if (count_in.day == '0) begin
            check_next.status = dcw_pkg::ST_BAD_DAY;
        end else if (thirty_month && (count_in.day > dcw_pkg::DayW'(30))) begin
            check_next.status = dcw_pkg::ST_OVER_30;
        end else if (!leap && feb && (count_in.day > dcw_pkg::DayW'(28))) begin
            check_next.status = dcw_pkg::ST_FEB_OVER_28;
        end else if (leap && feb && (count_in.day > dcw_pkg::DayW'(29))) begin
            check_next.status = dcw_pkg::ST_FEB_OVER_29;
        end else begin
            check_next.status = dcw_pkg::ST_OK;
        end

        // Day total, congruent mod 7 to the weekday index
        check_next.total = dcw_pkg::SumW'(count_in.year)
                         + dcw_pkg::SumW'(count_in.leaps)
                         - dcw_pkg::SumW'(leap)
                         + dcw_pkg::SumW'(dcw_pkg::days_before(count_in.month))
                         + dcw_pkg::SumW'(late_adj)
                         + dcw_pkg::SumW'(count_in.day)
                         + dcw_pkg::EpochOffset;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            check_reg <= check_next;
        end
    end

    assign check_out = check_reg;

endmodule

/* rtl/core/dcw_mod7_stage.sv */
module dcw_mod7_stage (
    input  logic                          aclk,
    input  logic                          adv,
    input  dcw_pkg::check_t               check_in,
    output logic [dcw_pkg::StatW-1:0]     status,
    output logic [dcw_pkg::WdayW-1:0]     weekday
);

    logic [dcw_pkg::StatW-1:0] status_reg, status_next;
    logic [dcw_pkg::WdayW-1:0] weekday_reg, weekday_next;
    logic [5:0] fold1;
    logic [3:0] fold2;
    logic [3:0] fold3;

    // Reduce mod 7 by summing octal digits, since 8 is 1 mod 7
    always_comb begin
        fold1 = 6'(check_in.total[2:0]) + 6'(check_in.total[5:3])
              + 6'(check_in.total[8:6]) + 6'(check_in.total[11:9])
              + 6'(check_in.total[14:12]);
        fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);
        fold3 = (fold2 >= 4'd7) ? (fold2 - 4'd7) : fold2;
        status_next  = check_in.status;
        weekday_next = (check_in.status == dcw_pkg::ST_OK) ? fold3[2:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            status_reg  <= status_next;
            weekday_reg <= weekday_next;
        end
    end

    assign status  = status_reg;
    assign weekday = weekday_reg;

endmodule

/* rtl/core/date_check_and_weekday.sv */
// Channel | Direction | Handshake          | Payload
// s_      | in        | s_valid / s_ready  | s_year_value, s_month_value, s_day_value
// m_      | out       | m_valid / m_ready  | m_status, m_weekday
//
// Four register stages: century split by multiplier, remainder and leap
// count, checks and day total, reduction mod 7 into the output register.
// One transaction per cycle unless m_ready stalls the pipe.
// aresetn (synchronous, active low) clears only the stage valid bits.
// A stall on m_ready holds the occupied stages ahead of the first empty one; the rest still fill.
module date_check_and_weekday (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [dcw_pkg::YearW-1:0]     s_year_value,
    input  logic [dcw_pkg::MonthW-1:0]    s_month_value,
    input  logic [dcw_pkg::DayW-1:0]      s_day_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [dcw_pkg::StatW-1:0]     m_status,
    output logic [dcw_pkg::WdayW-1:0]     m_weekday
);

    logic [3:0] vld_reg, vld_next;
    logic [3:0] adv;
    dcw_pkg::count_t count;
    dcw_pkg::check_t check;

    // Advance a stage when it is empty or the next one moves
    always_comb begin
        adv[3] = !vld_reg[3] || m_ready;
        adv[2] = !vld_reg[2] || adv[3];
        adv[1] = !vld_reg[1] || adv[2];
        adv[0] = !vld_reg[0] || adv[1];
    end

    // Move valid bits along with the data
    always_comb begin
        vld_next[0] = adv[0] ? s_valid    : vld_reg[0];
        vld_next[1] = adv[1] ? vld_reg[0] : vld_reg[1];
        vld_next[2] = adv[2] ? vld_reg[1] : vld_reg[2];
        vld_next[3] = adv[3] ? vld_reg[2] : vld_reg[3];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    dcw_year_stage u_year (
        .aclk        (aclk),
        .adv1        (adv[0]),
        .adv2        (adv[1]),
        .year_value  (s_year_value),
        .month_value (s_month_value),
        .day_value   (s_day_value),
        .count_out   (count)
    );

    dcw_check_stage u_check (
        .aclk      (aclk),
        .adv       (adv[2]),
        .count_in  (count),
        .check_out (check)
    );

    dcw_mod7_stage u_mod7 (
        .aclk     (aclk),
        .adv      (adv[3]),
        .check_in (check),
        .status   (m_status),
        .weekday  (m_weekday)
    );

    assign s_ready = adv[0];
    assign m_valid = vld_reg[3];

endmodule
